[hdl/utf8_decoder_top_assert.svh]
// assertion macros for the utf8 decoder modules
// expects clk and rst_n in the scope of each use
`ifndef UTF8_DECODER_TOP_ASSERT_SVH
`define UTF8_DECODER_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define UTF8D_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/utf8d_pkg.sv]
// shared types and constants for the utf8 decoder
// no dependencies
package utf8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned LEFT_W = 2;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_TRUNC    = 2'd2
  } utf8d_status_t;

  typedef struct packed {
    logic [CP_W-1:0] char_code;
    utf8d_status_t   status;
    logic            final_res;
  } utf8d_res_t;

  // result of one decode step toward the output buffer
  typedef struct packed {
    logic       valid;
    utf8d_res_t res;
  } utf8d_push_t;

endpackage

[hdl/utf8d_step.sv]
// decode step: sequence state registers and the per-byte update
// depends on utf8d_pkg and utf8_decoder_top_assert.svh
`include "utf8_decoder_top_assert.svh"

module utf8d_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [utf8d_pkg::BYTE_W-1:0]  byte_in,
  input  logic                          end_of_stream,
  output utf8d_pkg::utf8d_push_t        push
);
  import utf8d_pkg::*;

  logic [LEFT_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [CP_W-1:0]   acc_r, acc_nxt;
  logic [CP_W-1:0]   acc_shift;
  logic [LEFT_W-1:0] left_dec;
  logic              trunc_push;

  assign acc_shift  = {acc_r[CP_W-7:0], byte_in[5:0]};
  assign left_dec   = bytes_left_r - LEFT_W'(1);
  assign trunc_push = push.valid && (push.res.status == ST_TRUNC);

  always_comb begin
    bytes_left_nxt        = bytes_left_r;
    acc_nxt               = acc_r;
    push.valid            = 1'b0;
    push.res.char_code    = '0;
    push.res.status       = ST_OK;
    push.res.final_res    = end_of_stream;
    if (bytes_left_r == '0) begin
      if (!byte_in[7]) begin
        push.valid         = 1'b1;
        push.res.char_code = CP_W'(byte_in);
      end else if (byte_in[7:5] == 3'b110) begin
        acc_nxt        = CP_W'(byte_in[4:0]);
        bytes_left_nxt = LEFT_W'(1);
      end else if (byte_in[7:4] == 4'b1110) begin
        acc_nxt        = CP_W'(byte_in[3:0]);
        bytes_left_nxt = LEFT_W'(2);
      end else if (byte_in[7:3] == 5'b11110) begin
        acc_nxt        = CP_W'(byte_in[2:0]);
        bytes_left_nxt = LEFT_W'(3);
      end else begin
        push.valid      = 1'b1;
        push.res.status = ST_BAD_LEAD;
        acc_nxt         = '0;
        bytes_left_nxt  = '0;
      end
    end else begin
      acc_nxt        = acc_shift;
      bytes_left_nxt = left_dec;
      if (left_dec == '0) begin
        push.valid         = 1'b1;
        push.res.char_code = acc_shift;
        acc_nxt            = '0;
      end
    end
    // sequence still open on the last byte of the stream
    if (!push.valid && end_of_stream) begin
      push.valid         = 1'b1;
      push.res.status    = ST_TRUNC;
      push.res.char_code = '0;
      push.res.final_res = 1'b1;
      acc_nxt            = '0;
      bytes_left_nxt     = '0;
    end
    if (!accept) begin
      push.valid     = 1'b0;
      bytes_left_nxt = bytes_left_r;
      acc_nxt        = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      acc_r        <= '0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      acc_r        <= acc_nxt;
    end
  end

  `UTF8D_ASSERT_NEXT(a_eos_clears, accept && end_of_stream, bytes_left_r == '0, "open at eos")
  `UTF8D_ASSERT_IMPL(a_open_no_push, accept && push.valid, bytes_left_nxt == '0, "open at result")
  `UTF8D_ASSERT_IMPL(a_trunc_fin, trunc_push, push.res.final_res, "trunc not last")

endmodule

[hdl/utf8d_outbuf.sv]
// two-stage result buffer: main output register plus skid register
// depends on utf8d_pkg and utf8_decoder_top_assert.svh
`include "utf8_decoder_top_assert.svh"

module utf8d_outbuf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  utf8d_pkg::utf8d_push_t  push,
  output logic                    full,
  output logic                    out_valid,
  input  logic                    out_stall,
  output utf8d_pkg::utf8d_res_t   out_res
);
  import utf8d_pkg::*;

  logic       m_valid_r, m_valid_nxt;
  logic       s_valid_r, s_valid_nxt;
  utf8d_res_t m_res_r, m_res_nxt;
  utf8d_res_t s_res_r, s_res_nxt;
  logic       pop;
  logic       err_out;

  assign pop       = m_valid_r && !out_stall;
  assign full      = s_valid_r;
  assign out_valid = m_valid_r;
  assign out_res   = m_res_r;
  assign err_out   = m_valid_r && (m_res_r.status != ST_OK);

  // a push never arrives while the skid holds a transfer
  always_comb begin
    m_valid_nxt = m_valid_r;
    s_valid_nxt = s_valid_r;
    m_res_nxt   = m_res_r;
    s_res_nxt   = s_res_r;
    if (pop) begin
      if (s_valid_r) begin
        m_res_nxt   = s_res_r;
        s_valid_nxt = 1'b0;
      end else begin
        m_valid_nxt = push.valid;
        m_res_nxt   = push.res;
      end
    end else if (push.valid) begin
      if (!m_valid_r) begin
        m_valid_nxt = 1'b1;
        m_res_nxt   = push.res;
      end else begin
        s_valid_nxt = 1'b1;
        s_res_nxt   = push.res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
    end else begin
      m_valid_r <= m_valid_nxt;
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_res_r <= m_res_nxt;
    s_res_r <= s_res_nxt;
  end

  `UTF8D_ASSERT_IMPL(a_skid_needs_main, s_valid_r, m_valid_r, "skid valid without main")
  `UTF8D_ASSERT_IMPL(a_no_push_when_full, s_valid_r, !push.valid, "push while buffer full")
  `UTF8D_ASSERT_NEXT(a_skid_drains, pop && s_valid_r, m_valid_r && !s_valid_r, "skid not moved")
  `UTF8D_ASSERT_IMPL(a_err_zero_cp, err_out, m_res_r.char_code == '0, "error value nonzero")

endmodule

[hdl/utf8_decoder_top.sv]
// utf8 decoder top level: decode step feeding a two-stage result buffer
// depends on utf8d_pkg, utf8d_step, utf8d_outbuf
//
//   channel  handshake             payload
//   in       in_valid / in_stall   in_byte_in[7:0], in_end_of_stream
//   out      out_valid / out_stall out_char_code[20:0], out_status[1:0], out_final_res
//
// one byte per cycle unless in_stall; a result is registered in the buffer before it shows
// the decode step is a mask, a 6-bit shift and a 2-bit count between state and buffer regs
// in_stall rises once a second result lands while the first is stalled, drops after it drains
// bytes that close no result pass through even while one result waits, until the skid fills
// synchronous active-low reset clears the sequence state and the buffer
module utf8_decoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [utf8d_pkg::BYTE_W-1:0]  in_byte_in,
  input  logic                          in_end_of_stream,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [utf8d_pkg::CP_W-1:0]    out_char_code,
  output logic [utf8d_pkg::ST_W-1:0]    out_status,
  output logic                          out_final_res
);
  import utf8d_pkg::*;

  utf8d_push_t push;
  utf8d_res_t  res;
  logic        full;
  logic        accept;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  utf8d_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .byte_in       (in_byte_in),
    .end_of_stream (in_end_of_stream),
    .push          (push)
  );

  utf8d_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_char_code = res.char_code;
  assign out_status    = ST_W'(res.status);
  assign out_final_res = res.final_res;

endmodule

[bench/utf8_decoder_top_test.sv]
// self-checking bench for utf8_decoder_top: directed byte table, then random sequences
// depends on utf8d_pkg and the utf8_decoder_top rtl
`timescale 1ns / 1ps

module utf8_decoder_top_test;
  import utf8d_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_RESULT
  } row_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              eos;
    row_kind_t         kind;
    logic [CP_W-1:0]   cp;
    utf8d_status_t     st;
  } byte_row_t;

  localparam int unsigned NUM_ROWS = 25;

  // typed rows carry final_res equal to their end-of-stream flag
  localparam byte_row_t BYTE_TABLE [NUM_ROWS] = '{
    '{8'h00, 1'b0, ROW_RESULT,  21'h000000, ST_OK},
    '{8'h7F, 1'b0, ROW_RESULT,  21'h00007F, ST_OK},
    '{8'h80, 1'b0, ROW_RESULT,  21'h000000, ST_BAD_LEAD},
    '{8'hFF, 1'b1, ROW_RESULT,  21'h000000, ST_BAD_LEAD},
    '{8'hF8, 1'b0, ROW_RESULT,  21'h000000, ST_BAD_LEAD},
    '{8'hC2, 1'b0, ROW_SILENT,  21'h000000, ST_OK},
    '{8'hA9, 1'b0, ROW_PREDICT, 21'h000000, ST_OK},
    '{8'hE2, 1'b0, ROW_SILENT,  21'h000000, ST_OK},
    '{8'h82, 1'b0, ROW_SILENT,  21'h000000, ST_OK},
    '{8'hAC, 1'b0, ROW_PREDICT, 21'h000000, ST_OK},
    '{8'hF0, 1'b0, ROW_SILENT,  21'h000000, ST_OK},
    '{8'h9F, 1'b0, ROW_SILENT,  21'h000000, ST_OK},
    '{8'h98, 1'b0, ROW_SILENT,  21'h000000, ST_OK},
    '{8'h80, 1'b0, ROW_PREDICT, 21'h000000, ST_OK},
    // largest value a four-byte sequence can carry, no range check
    '{8'hF7, 1'b0, ROW_SILENT,  21'h000000, ST_OK},
    '{8'hFF, 1'b0, ROW_SILENT,  21'h000000, ST_OK},
    '{8'hFF, 1'b0, ROW_SILENT,  21'h000000, ST_OK},
    '{8'hFF, 1'b0, ROW_RESULT,  21'h1FFFFF, ST_OK},
    // continuation without the 10 prefix only contributes its low six bits
    '{8'hC3, 1'b0, ROW_SILENT,  21'h000000, ST_OK},
    '{8'h41, 1'b0, ROW_PREDICT, 21'h000000, ST_OK},
    // sequences cut short by end of stream, then a plain byte that ends the stream
    '{8'hE0, 1'b1, ROW_RESULT,  21'h000000, ST_TRUNC},
    '{8'hF0, 1'b0, ROW_SILENT,  21'h000000, ST_OK},
    '{8'h80, 1'b0, ROW_SILENT,  21'h000000, ST_OK},
    '{8'h80, 1'b1, ROW_RESULT,  21'h000000, ST_TRUNC},
    '{8'h41, 1'b1, ROW_RESULT,  21'h000041, ST_OK}
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] in_byte_in;
  logic              in_end_of_stream;
  logic              out_valid;
  logic              out_stall;
  logic [CP_W-1:0]   out_char_code;
  logic [ST_W-1:0]   out_status;
  logic              out_final_res;

  utf8_decoder_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_in       (in_byte_in),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char_code    (out_char_code),
    .out_status       (out_status),
    .out_final_res    (out_final_res)
  );

  // decoder state mirrored by the bench
  logic [LEFT_W-1:0] cont_left;
  logic [CP_W-1:0]   cp_acc;

  utf8d_res_t  pending_cps[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // one decode step; returns 1 when the byte closes a result
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic eos,
                                     output utf8d_res_t res);
    res = '0;
    res.final_res = eos;
    if (cont_left == 2'd0) begin
      if (b[7] == 1'b0) begin
        res.char_code = CP_W'(b);
        res.status = ST_OK;
        return 1'b1;
      end else if (b[7:5] == 3'b110) begin
        cp_acc = CP_W'(b[4:0]);
        cont_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        cp_acc = CP_W'(b[3:0]);
        cont_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        cp_acc = CP_W'(b[2:0]);
        cont_left = 2'd3;
      end else begin
        cont_left = 2'd0;
        cp_acc = '0;
        res.status = ST_BAD_LEAD;
        return 1'b1;
      end
    end else begin
      cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        res.char_code = cp_acc;
        res.status = ST_OK;
        cp_acc = '0;
        return 1'b1;
      end
    end
    if (eos) begin
      cont_left = 2'd0;
      cp_acc = '0;
      res.status = ST_TRUNC;
      res.final_res = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // drive one byte until the transfer happens, then record what it should produce
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos,
                           input row_kind_t kind, input utf8d_res_t typed_res);
    utf8d_res_t predicted;
    bit         has_res;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte_in <= b;
    in_end_of_stream <= eos;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    has_res = decode_byte(b, eos, predicted);
    if (kind == ROW_RESULT)
      pending_cps.insert(pending_cps.size(), typed_res);
    else if (kind == ROW_PREDICT && has_res)
      pending_cps.insert(pending_cps.size(), predicted);
  endtask

  function automatic logic [BYTE_W-1:0] lead_byte(input int unsigned conts);
    case (conts)
      1: return 8'hC0 | BYTE_W'($urandom_range(0, 31));
      2: return 8'hE0 | BYTE_W'($urandom_range(0, 15));
      default: return 8'hF0 | BYTE_W'($urandom_range(0, 7));
    endcase
  endfunction

  // one random group: mostly well-formed sequences, some noise and broken ones
  task automatic send_random_group();
    logic [BYTE_W-1:0] seq[$];
    int unsigned       pick;
    int unsigned       conts;
    int unsigned       i;
    bit                cut_short;
    logic              eos;
    cut_short = 1'b0;
    pick = $urandom_range(0, 99);
    conts = $urandom_range(1, 3);
    if (pick < 25) begin
      seq.insert(seq.size(), BYTE_W'($urandom_range(0, 127)));
    end else if (pick < 80) begin
      conts = (pick < 45) ? 1 : (pick < 62) ? 2 : 3;
      seq.insert(seq.size(), lead_byte(conts));
      for (i = 0; i < conts; i++)
        seq.insert(seq.size(), 8'h80 | BYTE_W'($urandom_range(0, 63)));
    end else if (pick < 88) begin
      seq.insert(seq.size(), BYTE_W'($urandom_range(0, 255)));
    end else if (pick < 95) begin
      cut_short = 1'b1;
      seq.insert(seq.size(), lead_byte(conts));
      for (i = $urandom_range(0, conts - 1); i > 0; i--)
        seq.insert(seq.size(), 8'h80 | BYTE_W'($urandom_range(0, 63)));
    end else begin
      seq.insert(seq.size(), lead_byte(conts));
      for (i = 0; i < conts; i++)
        seq.insert(seq.size(), BYTE_W'($urandom_range(0, 255)));
    end
    for (i = 0; i < seq.size(); i++) begin
      eos = (cut_short && i == seq.size() - 1) || ($urandom_range(0, 24) == 0);
      send_byte(seq[i], eos, ROW_PREDICT, '0);
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    utf8d_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cps.size() == 0) begin
        if (fail_count < 10)
          $display("%0t: unexpected result cp=%h status=%0d final=%0b", $realtime,
                   out_char_code, out_status, out_final_res);
        fail_count++;
      end else begin
        want = pending_cps.pop_front();
        if (out_char_code !== want.char_code || out_status !== want.status ||
            out_final_res !== want.final_res) begin
          if (fail_count < 10)
            $display("%0t: exp cp=%h st=%0d fin=%0b, got cp=%h st=%0d fin=%0b",
                     $realtime, want.char_code, want.status, want.final_res,
                     out_char_code, out_status, out_final_res);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    utf8d_res_t row_res;
    int unsigned phase;
    int unsigned r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte_in = '0;
    in_end_of_stream = 1'b0;
    cont_left = '0;
    cp_acc = '0;
    bytes_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < NUM_ROWS; r++) begin
      row_res.char_code = BYTE_TABLE[r].cp;
      row_res.status = BYTE_TABLE[r].st;
      row_res.final_res = BYTE_TABLE[r].eos;
      send_byte(BYTE_TABLE[r].b, BYTE_TABLE[r].eos, BYTE_TABLE[r].kind, row_res);
    end

    // idle mix per phase: none, sender only, receiver only, both
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      while (bytes_sent < NUM_ROWS + (phase + 1) * (RANDOM_ITEMS / 4))
        send_random_group();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_cps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
